/* design/mlp_pkg.sv */
// Shared types, constants and fixed-point helpers of the two-layer perceptron unit.
// Depends on nothing; every other design file imports it.
package mlp_pkg;

  localparam int DATA_W        = 16;
  localparam int ACC_W         = 40;
  localparam int LR_W          = 13;
  localparam int HIDDEN_DEF    = 4;
  localparam int SIG_DEPTH_DEF = 256;
  localparam int ONE_Q12       = 4096;
  localparam logic [LR_W-1:0] LR_RESET = 13'd41;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_INFER = 2'd1,
    CMD_TRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_LRATE = 1'b1;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W:0] v);
    if (v > 32767) begin
      return 16'sh7fff;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return v[DATA_W-1:0];
  endfunction

  // Round a Q16.24 sum to Q4.12 (floor of v/4096 + 1/2) and saturate.
  function automatic logic signed [DATA_W-1:0] rsat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] t;
    t = $signed({v[ACC_W-1], v}) + $signed((ACC_W+1)'(2048));
    return sat16(t >>> 12);
  endfunction

  // e^(-a) in Q30 for a in Q12; used only to build the sigmoid table.
  function automatic longint unsigned exp_neg_q30(input longint unsigned a);
    longint unsigned b, b2, b3, b4, e;
    b  = a << 10;
    b2 = (b * b) >> 30;
    b3 = (b2 * b) >> 30;
    b4 = (b3 * b) >> 30;
    e  = (ONE_Q30 + b2 / 2 + b4 / 24) - b - b3 / 6;
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (ONE_Q30 >> 1)) >> 30;
    end
    return e;
  endfunction

endpackage

/* design/mlp_act.sv */
// Activation unit: sigmoid and sigmoid-derivative tables with a registered read, plus ReLU.
// Depends on mlp_pkg.
module mlp_act #(
  parameter int SigDepth = mlp_pkg::SIG_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                ld,
  input  logic                                mode,
  input  logic signed [mlp_pkg::DATA_W-1:0]   z,
  output logic signed [mlp_pkg::DATA_W-1:0]   z_q,
  output logic signed [mlp_pkg::DATA_W-1:0]   a,
  output logic signed [mlp_pkg::DATA_W-1:0]   d
);
  import mlp_pkg::*;

  localparam int IdxW = $clog2(SigDepth);

  logic [12:0]        sig_rom [SigDepth];
  logic [10:0]        drv_rom [SigDepth];
  logic [12:0]        s_q;
  logic [10:0]        ds_q;
  logic [31:0]        scaled;
  logic [IdxW-1:0]    idx;

  for (genvar k = 0; k < SigDepth; k++) begin : g_rom
    localparam longint C = longint'(((2 * k + 1) * 65536) / (2 * SigDepth)) - 64'sd32768;
    localparam longint unsigned MAG = (C < 0) ? longint'(-C) : longint'(C);
    localparam longint unsigned DEN = ONE_Q30 + exp_neg_q30(MAG);
    localparam longint unsigned S   = ((64'd4096 << 30) + (DEN >> 1)) / DEN;
    localparam longint unsigned V   = (C < 0) ? (64'd4096 - S) : S;
    localparam longint unsigned D   = (V * (64'd4096 - V) + 64'd2048) >> 12;
    assign sig_rom[k] = 13'(V);
    assign drv_rom[k] = 11'(D);
  end

  // Offset z into the unsigned range and scale it onto the table bins.
  assign scaled = 32'({~z[DATA_W-1], z[DATA_W-2:0]}) * 32'(SigDepth);
  assign idx    = scaled[16 +: IdxW];

  always_ff @(posedge clk) begin
    if (ld) begin
      z_q  <= z;
      s_q  <= sig_rom[idx];
      ds_q <= drv_rom[idx];
    end
  end

  always_comb begin
    if (mode) begin
      a = (z_q > 0) ? z_q : '0;
      d = (z_q > 0) ? 16'(ONE_Q12) : '0;
    end else begin
      a = $signed({3'b000, s_q});
      d = $signed({5'b00000, ds_q});
    end
  end

endmodule

/* design/mlp_infer_and_sgd_train_unit.sv */
// Top level of the two-layer perceptron: sequencer, shared multiply-accumulate,
// parameter memory and hidden-layer scratch memory. Depends on mlp_pkg and mlp_act.

// All weights and biases live in one single-port parameter memory and every product goes
// through one multiply-accumulate. A load or an unused command is answered from idle, an
// inference runs one forward pass and a training step two forward passes and the updates,
// one read-modify-write per output parameter and one per hidden parameter for each output.
// After reset a clearing pass sets the weights to zero and the biases to one; busy is high
// meanwhile. A result is shown for one cycle on out_valid and must be taken then;
// configuration is to be written by the user only while busy is low; not enforced here.
module mlp_infer_and_sgd_train_unit #(
  parameter int Hidden   = mlp_pkg::HIDDEN_DEF,
  parameter int SigDepth = mlp_pkg::SIG_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic signed [mlp_pkg::DATA_W-1:0]   in_x_first,
  input  logic signed [mlp_pkg::DATA_W-1:0]   in_x_second,
  input  logic signed [mlp_pkg::DATA_W-1:0]   in_target_first,
  input  logic signed [mlp_pkg::DATA_W-1:0]   in_target_second,
  input  logic [4:0]                          in_param_index,
  input  logic signed [mlp_pkg::DATA_W-1:0]   in_param_value,
  output logic                                out_valid,
  output logic signed [mlp_pkg::DATA_W-1:0]   out_y_first,
  output logic signed [mlp_pkg::DATA_W-1:0]   out_y_second,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [mlp_pkg::LR_W-1:0]            cfg_data
);
  import mlp_pkg::*;

  localparam int NSlots = 5 * Hidden + 2;
  localparam int SlotW  = $clog2(NSlots);
  localparam int HIdxW  = (Hidden > 1) ? $clog2(Hidden) : 1;
  localparam int OwBase = 2 * Hidden;
  localparam int HbBase = 4 * Hidden;
  localparam int ObBase = 5 * Hidden;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_H_RD0, S_H_M0, S_H_RD1, S_H_M1, S_H_RDB, S_H_MB, S_H_Z, S_H_A,
    S_O_RDB, S_O_MB, S_O_RD, S_O_M, S_O_Z, S_O_A,
    S_T0, S_T1, S_T2,
    S_U_RD, S_U_G, S_U_L, S_U_W,
    S_V_RD, S_V_M, S_V_P, S_V_D, S_V_Z
  } state_t;

  typedef enum logic [1:0] {K_OW, K_OB, K_HW, K_HB} kind_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  logic [HIdxW-1:0] h_r, h_nxt;
  logic             j_r, j_nxt, o_r, o_nxt, fo_r, fo_nxt;
  logic [SlotW-1:0] clr_r, clr_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic             mode_r;
  logic [LR_W-1:0]  lr_r;
  logic             out_valid_r, out_valid_nxt;

  logic signed [DATA_W-1:0] x0_r, x0_nxt, x1_r, x1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic signed [DATA_W-1:0] p_r, p_nxt, dz_r, dz_nxt, dz1_r, dz1_nxt, dp1_r, dp1_nxt;
  logic signed [DATA_W-1:0] z2_r [2];
  logic signed [DATA_W-1:0] a2_r [2];
  logic signed [DATA_W-1:0] z2_nxt [2];
  logic signed [DATA_W-1:0] a2_nxt [2];
  logic signed [DATA_W-1:0] y0_r, y0_nxt, y1_r, y1_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  // Parameter memory and hidden scratch memory (z1 in the upper half, a1 in the lower).
  logic signed [DATA_W-1:0] pmem [NSlots];
  logic signed [DATA_W-1:0] pq;
  logic [SlotW-1:0]         paddr;
  logic                     pwe;
  logic signed [DATA_W-1:0] pwdata;
  logic [2*DATA_W-1:0]      smem [Hidden];
  logic [2*DATA_W-1:0]      sq;
  logic                     swe;

  logic [SlotW-1:0] a_hw, a_ow, a_ow_fo, a_hb, a_ob, a_ob_fo, a_upd;
  logic             h_last;

  logic signed [16:0]       ma, mb;
  logic signed [33:0]       prod;
  logic                     mac_en, mac_clr;
  logic signed [DATA_W-1:0] g_acc, a1, z1, asel, tsel, dpred;
  logic signed [17:0]       dd;
  logic signed [DATA_W:0]   diff;

  logic                     act_ld;
  logic signed [DATA_W-1:0] act_z, act_zq, act_a, act_d;

  mlp_act #(
    .SigDepth (SigDepth)
  ) u_act (
    .clk  (clk),
    .ld   (act_ld),
    .mode (mode_r),
    .z    (act_z),
    .z_q  (act_zq),
    .a    (act_a),
    .d    (act_d)
  );

  assign a_hw    = SlotW'(2 * int'(h_r) + int'(j_r));
  assign a_ow    = SlotW'(OwBase + (o_r ? Hidden : 0) + int'(h_r));
  assign a_ow_fo = SlotW'(OwBase + (fo_r ? Hidden : 0) + int'(h_r));
  assign a_hb    = SlotW'(HbBase + int'(h_r));
  assign a_ob    = SlotW'(ObBase + int'(o_r));
  assign a_ob_fo = SlotW'(ObBase + int'(fo_r));
  assign h_last  = (h_r == HIdxW'(Hidden - 1));

  always_comb begin
    case (kind_r)
      K_OW:    a_upd = a_ow;
      K_OB:    a_upd = a_ob;
      K_HW:    a_upd = a_hw;
      K_HB:    a_upd = a_hb;
      default: a_upd = a_ob;
    endcase
  end

  assign prod  = ma * mb;
  assign g_acc = rsat(acc_r);
  assign a1    = $signed(sq[DATA_W-1:0]);
  assign z1    = $signed(sq[2*DATA_W-1:DATA_W]);
  assign asel  = o_r ? a2_r[1] : a2_r[0];
  assign tsel  = o_r ? t1_r : t0_r;
  assign dd    = $signed({asel[DATA_W-1], asel, 1'b0}) - $signed({tsel[DATA_W-1], tsel, 1'b0});
  assign dpred = sat16($signed({{(ACC_W-17){dd[17]}}, dd}));
  assign diff  = $signed({p_r[DATA_W-1], p_r}) - $signed({g_acc[DATA_W-1], g_acc});

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    h_nxt         = h_r;
    j_nxt         = j_r;
    o_nxt         = o_r;
    fo_nxt        = fo_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    p_nxt         = p_r;
    dz_nxt        = dz_r;
    dz1_nxt       = dz1_r;
    dp1_nxt       = dp1_r;
    z2_nxt        = z2_r;
    a2_nxt        = a2_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    out_valid_nxt = 1'b0;
    mac_en        = 1'b0;
    mac_clr       = 1'b0;
    ma            = '0;
    mb            = '0;
    paddr         = a_hw;
    pwe           = 1'b0;
    pwdata        = '0;
    swe           = 1'b0;
    act_ld        = 1'b0;
    act_z         = g_acc;

    case (state_r)
      S_CLR: begin
        pwe    = 1'b1;
        paddr  = clr_r;
        pwdata = (int'(clr_r) >= HbBase) ? 16'(ONE_Q12) : '0;
        if (clr_r == SlotW'(NSlots - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          x0_nxt  = in_x_first;
          x1_nxt  = in_x_second;
          t0_nxt  = in_target_first;
          t1_nxt  = in_target_second;
          h_nxt   = '0;
          j_nxt   = 1'b0;
          o_nxt   = 1'b0;
          fo_nxt  = 1'b0;
          case (in_cmd)
            CMD_INFER, CMD_TRAIN: begin
              state_nxt = S_H_RD0;
            end
            CMD_LOAD: begin
              if (32'(in_param_index) < 32'(NSlots)) begin
                pwe    = 1'b1;
                paddr  = SlotW'(in_param_index);
                pwdata = in_param_value;
              end
              y0_nxt        = '0;
              y1_nxt        = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              y0_nxt        = '0;
              y1_nxt        = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_H_RD0: begin
        paddr     = a_hw;
        state_nxt = S_H_M0;
      end
      S_H_M0: begin
        ma        = {x0_r[DATA_W-1], x0_r};
        mb        = {pq[DATA_W-1], pq};
        mac_en    = 1'b1;
        mac_clr   = 1'b1;
        j_nxt     = 1'b1;
        state_nxt = S_H_RD1;
      end
      S_H_RD1: begin
        paddr     = a_hw;
        state_nxt = S_H_M1;
      end
      S_H_M1: begin
        ma        = {x1_r[DATA_W-1], x1_r};
        mb        = {pq[DATA_W-1], pq};
        mac_en    = 1'b1;
        j_nxt     = 1'b0;
        state_nxt = S_H_RDB;
      end
      S_H_RDB: begin
        paddr     = a_hb;
        state_nxt = S_H_MB;
      end
      S_H_MB: begin
        ma        = {pq[DATA_W-1], pq};
        mb        = 17'(ONE_Q12);
        mac_en    = 1'b1;
        state_nxt = S_H_Z;
      end
      S_H_Z: begin
        act_ld    = 1'b1;
        state_nxt = S_H_A;
      end
      S_H_A: begin
        swe = 1'b1;
        if (h_last) begin
          h_nxt     = '0;
          state_nxt = S_O_RDB;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_H_RD0;
        end
      end
      S_O_RDB: begin
        paddr     = a_ob_fo;
        state_nxt = S_O_MB;
      end
      S_O_MB: begin
        ma        = {pq[DATA_W-1], pq};
        mb        = 17'(ONE_Q12);
        mac_en    = 1'b1;
        mac_clr   = 1'b1;
        h_nxt     = '0;
        state_nxt = S_O_RD;
      end
      S_O_RD: begin
        paddr     = a_ow_fo;
        state_nxt = S_O_M;
      end
      S_O_M: begin
        ma     = {a1[DATA_W-1], a1};
        mb     = {pq[DATA_W-1], pq};
        mac_en = 1'b1;
        if (h_last) begin
          h_nxt     = '0;
          state_nxt = S_O_Z;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_O_RD;
        end
      end
      S_O_Z: begin
        act_ld    = 1'b1;
        state_nxt = S_O_A;
      end
      S_O_A: begin
        z2_nxt[fo_r] = act_zq;
        a2_nxt[fo_r] = act_a;
        if (!fo_r) begin
          fo_nxt    = 1'b1;
          state_nxt = S_O_RDB;
        end else if (cmd_r == CMD_INFER) begin
          y0_nxt        = a2_r[0];
          y1_nxt        = act_a;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // The result of a training step comes from its first forward pass.
          if (!o_r) begin
            y0_nxt = a2_r[0];
            y1_nxt = act_a;
          end
          state_nxt = S_T0;
        end
      end
      S_T0: begin
        act_ld    = 1'b1;
        act_z     = o_r ? z2_r[1] : z2_r[0];
        state_nxt = S_T1;
      end
      S_T1: begin
        ma        = {dpred[DATA_W-1], dpred};
        mb        = {act_d[DATA_W-1], act_d};
        mac_en    = 1'b1;
        mac_clr   = 1'b1;
        state_nxt = S_T2;
      end
      S_T2: begin
        dz_nxt    = g_acc;
        h_nxt     = '0;
        kind_nxt  = K_OW;
        state_nxt = S_U_RD;
      end
      S_U_RD: begin
        paddr     = a_upd;
        state_nxt = S_U_G;
      end
      S_U_G: begin
        p_nxt   = pq;
        mac_en  = 1'b1;
        mac_clr = 1'b1;
        case (kind_r)
          K_OW: begin
            ma = {dz_r[DATA_W-1], dz_r};
            mb = {a1[DATA_W-1], a1};
          end
          K_OB: begin
            ma = {dz_r[DATA_W-1], dz_r};
            mb = 17'(ONE_Q12);
          end
          K_HW: begin
            ma = {dz1_r[DATA_W-1], dz1_r};
            mb = j_r ? {x1_r[DATA_W-1], x1_r} : {x0_r[DATA_W-1], x0_r};
          end
          default: begin
            ma = {dz1_r[DATA_W-1], dz1_r};
            mb = 17'(ONE_Q12);
          end
        endcase
        state_nxt = S_U_L;
      end
      S_U_L: begin
        ma        = {4'b0000, lr_r};
        mb        = {g_acc[DATA_W-1], g_acc};
        mac_en    = 1'b1;
        mac_clr   = 1'b1;
        state_nxt = S_U_W;
      end
      S_U_W: begin
        pwe    = 1'b1;
        paddr  = a_upd;
        pwdata = sat16($signed({{(ACC_W-DATA_W){diff[DATA_W]}}, diff}));
        case (kind_r)
          K_OW: begin
            if (h_last) begin
              h_nxt    = '0;
              kind_nxt = K_OB;
            end else begin
              h_nxt = h_r + 1'b1;
            end
            state_nxt = S_U_RD;
          end
          K_OB: begin
            h_nxt     = '0;
            state_nxt = S_V_RD;
          end
          K_HW: begin
            if (!j_r) begin
              j_nxt = 1'b1;
            end else begin
              j_nxt    = 1'b0;
              kind_nxt = K_HB;
            end
            state_nxt = S_U_RD;
          end
          default: begin
            if (!h_last) begin
              h_nxt     = h_r + 1'b1;
              state_nxt = S_V_RD;
            end else if (!o_r) begin
              o_nxt     = 1'b1;
              h_nxt     = '0;
              fo_nxt    = 1'b0;
              state_nxt = S_H_RD0;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end
      S_V_RD: begin
        // Reads the output weight just updated for this output.
        paddr     = a_ow;
        state_nxt = S_V_M;
      end
      S_V_M: begin
        ma        = {pq[DATA_W-1], pq};
        mb        = {dz_r[DATA_W-1], dz_r};
        mac_en    = 1'b1;
        mac_clr   = 1'b1;
        act_ld    = 1'b1;
        act_z     = z1;
        state_nxt = S_V_P;
      end
      S_V_P: begin
        dp1_nxt   = g_acc;
        state_nxt = S_V_D;
      end
      S_V_D: begin
        ma        = {dp1_r[DATA_W-1], dp1_r};
        mb        = {act_d[DATA_W-1], act_d};
        mac_en    = 1'b1;
        mac_clr   = 1'b1;
        state_nxt = S_V_Z;
      end
      S_V_Z: begin
        dz1_nxt   = g_acc;
        j_nxt     = 1'b0;
        kind_nxt  = K_HW;
        state_nxt = S_U_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mac_en) begin
      acc_nxt = (mac_clr ? '0 : acc_r) + $signed({{(ACC_W-34){prod[33]}}, prod});
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pmem[paddr] <= pwdata;
    end
    pq <= pmem[paddr];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[h_r] <= {act_zq, act_a};
    end
    sq <= smem[h_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= K_OW;
      h_r         <= '0;
      j_r         <= 1'b0;
      o_r         <= 1'b0;
      fo_r        <= 1'b0;
      cmd_r       <= CMD_NONE;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      h_r         <= h_nxt;
      j_r         <= j_nxt;
      o_r         <= o_nxt;
      fo_r        <= fo_nxt;
      cmd_r       <= cmd_nxt;
    end
    x0_r  <= x0_nxt;
    x1_r  <= x1_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    p_r   <= p_nxt;
    dz_r  <= dz_nxt;
    dz1_r <= dz1_nxt;
    dp1_r <= dp1_nxt;
    z2_r  <= z2_nxt;
    a2_r  <= a2_nxt;
    y0_r  <= y0_nxt;
    y1_r  <= y1_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      lr_r   <= LR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_data[0];
      end else begin
        lr_r <= cfg_data;
      end
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_y_first  = y0_r;
  assign out_y_second = y1_r;

`ifndef SYNTHESIS
  a_result_only_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result beat shown while an item is still in progress");

  a_write_only_in_update : assert property (@(posedge clk) disable iff (!rst_n)
    pwe |-> (state_r == S_CLR || state_r == S_IDLE || state_r == S_U_W))
    else $error("parameter memory written outside a load, clear or update step");

  a_load_answers_next : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_LOAD) |=> (out_valid_r && out_y_first == 0))
    else $error("load did not give a zero result beat in the next cycle");
`endif

endmodule
